// ===== rtl/core/dpa_pkg.sv =====
// Shared constants, types and exponential tables of the attention head.
package dpa_pkg;

    localparam int SEQ_LEN_DEF  = 64;
    localparam int HEAD_DIM_DEF = 16;

    localparam int OPCODE_W   = 1;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 4;
    localparam int VAL_W      = 16;
    localparam int SEQ_CFG_W  = 7;
    localparam int DIM_CFG_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int SCORE_W    = 40;
    localparam int E_W        = 17;
    localparam int NUM_W      = 33;

    localparam logic [OPCODE_W-1:0] OP_LOAD    = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_COMPUTE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_DIM = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCORE,
        ST_EXP,
        ST_DIV,
        ST_OUT
    } state_t;

    function automatic logic [E_W-1:0] exp_int(input logic [3:0] i);
        logic [E_W-1:0] r;
        case (i)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd24109;
            4'd2:    r = 17'd8869;
            4'd3:    r = 17'd3263;
            4'd4:    r = 17'd1200;
            4'd5:    r = 17'd442;
            4'd6:    r = 17'd162;
            4'd7:    r = 17'd60;
            4'd8:    r = 17'd22;
            4'd9:    r = 17'd8;
            4'd10:   r = 17'd3;
            4'd11:   r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    function automatic logic [E_W-1:0] exp_frac(input logic [3:0] f);
        logic [E_W-1:0] r;
        case (f)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd61565;
            4'd2:    r = 17'd57835;
            4'd3:    r = 17'd54331;
            4'd4:    r = 17'd51039;
            4'd5:    r = 17'd47947;
            4'd6:    r = 17'd45042;
            4'd7:    r = 17'd42313;
            4'd8:    r = 17'd39750;
            4'd9:    r = 17'd37341;
            4'd10:   r = 17'd35079;
            4'd11:   r = 17'd32954;
            4'd12:   r = 17'd30957;
            4'd13:   r = 17'd29081;
            4'd14:   r = 17'd27319;
            default: r = 17'd25664;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/dpa_recip.sv =====
// Bit-serial restoring divider forming the rounded reciprocal of the exponential sum.
module dpa_recip #(
    parameter int SUM_W = 23
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [SUM_W-1:0]         divisor,
    output logic                     done,
    output logic [dpa_pkg::E_W-1:0]  quotient
);
    import dpa_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic                 run_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [SUM_W-1:0]     div_reg;
    logic [SUM_W-1:0]     rem_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [E_W-1:0]       quo_reg;
    logic                 done_reg;
    logic [SUM_W:0]       trial;
    logic                 ge;
    logic [SUM_W:0]       diff;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(NUM_W - 1);
            end
            else if (run_reg)
            begin
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            num_reg <= (NUM_W'(1) << 32) + NUM_W'(divisor >> 1);
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            num_reg <= num_reg << 1;
            quo_reg <= {quo_reg[E_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/dot_product_attention_head_top.sv =====
// Top level of the unscaled single-head attention block with its stores and sequencer.
//
// A load word writes one element of the query, key and value stores, and while busy is
// low loads may follow one another every cycle. A compute word runs four phases on the
// named query row, with n rows and d columns in use: the scores, the exponentials, the
// reciprocal and the weighted sums, in that order. The score and weighted-sum phases
// are bounded by the single read port of each store delivering one element per cycle.
// Busy stays high until the last phase is done. Results leave one column per strobe
// and cannot be held off by the receiver.
module dot_product_attention_head_top #(
    parameter int SEQ_LEN  = dpa_pkg::SEQ_LEN_DEF,
    parameter int HEAD_DIM = dpa_pkg::HEAD_DIM_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [dpa_pkg::OPCODE_W-1:0]          opcode,
    input  logic [dpa_pkg::ROW_W-1:0]             row,
    input  logic [dpa_pkg::COL_W-1:0]             col,
    input  logic signed [dpa_pkg::VAL_W-1:0]      q_value,
    input  logic signed [dpa_pkg::VAL_W-1:0]      k_value,
    input  logic signed [dpa_pkg::VAL_W-1:0]      v_value,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dpa_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dpa_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic                                  strobe,
    output logic [dpa_pkg::ROW_W-1:0]             out_row,
    output logic [dpa_pkg::COL_W-1:0]             out_col,
    output logic signed [dpa_pkg::VAL_W-1:0]      out_value,
    output logic                                  last
);
    import dpa_pkg::*;

    localparam int JW     = $clog2(SEQ_LEN);
    localparam int CW     = (HEAD_DIM > 1) ? $clog2(HEAD_DIM) : 1;
    localparam int DEPTH  = SEQ_LEN * HEAD_DIM;
    localparam int AW     = $clog2(DEPTH);
    localparam int SUM_W  = E_W + JW;
    localparam int PROD_W = 2 * VAL_W;
    localparam int WP_W   = 2 * E_W;
    localparam int PV_W   = E_W + 1 + VAL_W;
    localparam int ACC_W  = PV_W + JW;
    localparam int D_W    = SCORE_W + 1;
    localparam int IDX_W  = D_W - 20;

    state_t                    state_reg;
    state_t                    state_next;
    logic [SEQ_CFG_W-1:0]      seq_len_reg;
    logic [DIM_CFG_W-1:0]      head_dim_reg;
    logic [JW-1:0]             nm1;
    logic [CW-1:0]             dm1;
    logic                      accept;
    logic                      load_we;
    logic                      compute_go;
    logic                      phase_done;
    logic                      enter_phase;
    logic                      recip_start;
    logic                      recip_done;
    logic [E_W-1:0]            inv;

    logic [ROW_W-1:0]          row_reg;
    logic [JW-1:0]             j_reg;
    logic [CW-1:0]             c_reg;
    logic                      issue_reg;
    logic                      iss_first;
    logic                      iss_last;

    logic [AW-1:0]             ld_addr;
    logic [AW-1:0]             q_addr;
    logic [AW-1:0]             kv_addr;

    logic signed [VAL_W-1:0]   q_mem [DEPTH];
    logic signed [VAL_W-1:0]   k_mem [DEPTH];
    logic signed [VAL_W-1:0]   v_mem [DEPTH];
    logic signed [SCORE_W-1:0] score_mem [SEQ_LEN];
    logic [E_W-1:0]            weight_mem [SEQ_LEN];
    logic signed [VAL_W-1:0]   q_rd;
    logic signed [VAL_W-1:0]   k_rd;
    logic signed [VAL_W-1:0]   v_rd;
    logic signed [SCORE_W-1:0] s_rd;
    logic [E_W-1:0]            w_rd;

    logic                      p1v_reg;
    logic                      p2v_reg;
    logic                      p3v_reg;
    logic                      p1_first;
    logic                      p1_last;
    logic [JW-1:0]             p1_j;
    logic [CW-1:0]             p1_c;
    logic                      p2_first;
    logic                      p2_last;
    logic [JW-1:0]             p2_j;
    logic [CW-1:0]             p2_c;
    logic                      p3_first;
    logic                      p3_last;
    logic [JW-1:0]             p3_j;
    logic [CW-1:0]             p3_c;

    logic signed [PROD_W-1:0]  prod2;
    logic                      ez2;
    logic [3:0]                ei2;
    logic [3:0]                ef2;
    logic [WP_W-1:0]           wp2;
    logic signed [VAL_W-1:0]   v2;
    logic [E_W-1:0]            ei3;
    logic [E_W-1:0]            ef3;
    logic signed [PV_W-1:0]    prod3;

    logic signed [SCORE_W-1:0] acc_s_reg;
    logic signed [SCORE_W-1:0] acc_s_next;
    logic signed [SCORE_W-1:0] mx_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic signed [ACC_W-1:0]   acc_o_reg;
    logic signed [ACC_W-1:0]   acc_o_next;

    logic [D_W-1:0]            d_w;
    logic [D_W-1:0]            dpl;
    logic [IDX_W-1:0]          idx;
    logic [WP_W-1:0]           e_full;
    logic [E_W-1:0]            e4;
    logic [WP_W-1:0]           p_full;
    logic signed [E_W:0]       p_s;
    logic signed [ACC_W:0]     rnd;
    logic signed [ACC_W:0]     rsh;
    logic signed [VAL_W-1:0]   sat;
    logic                      strobe_reg;

    always_comb
    begin
        if (seq_len_reg == '0)
            nm1 = '0;
        else if (int'(seq_len_reg) > SEQ_LEN)
            nm1 = JW'(SEQ_LEN - 1);
        else
            nm1 = JW'(int'(seq_len_reg) - 1);
        if (head_dim_reg == '0)
            dm1 = '0;
        else if (int'(head_dim_reg) > HEAD_DIM)
            dm1 = CW'(HEAD_DIM - 1);
        else
            dm1 = CW'(int'(head_dim_reg) - 1);
    end

    assign ld_addr = AW'(int'(row) * HEAD_DIM + int'(col));
    assign q_addr  = AW'(int'(row_reg) * HEAD_DIM + int'(c_reg));
    assign kv_addr = AW'(int'(j_reg) * HEAD_DIM + int'(c_reg));

    assign phase_done = !issue_reg && !p1v_reg && !p2v_reg && !p3v_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (compute_go) state_next = ST_SCORE;
            ST_SCORE: if (phase_done) state_next = ST_EXP;
            ST_EXP:   if (phase_done) state_next = ST_DIV;
            ST_DIV:   if (recip_done) state_next = ST_OUT;
            ST_OUT:   if (phase_done) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy        = (state_reg != ST_IDLE);
        accept      = start && !busy;
        load_we     = accept && (opcode == OP_LOAD) &&
                      (int'(row) < SEQ_LEN) && (int'(col) < HEAD_DIM);
        compute_go  = accept && (opcode == OP_COMPUTE) && (int'(row) <= int'(nm1));
        recip_start = (state_reg == ST_EXP) && (state_next == ST_DIV);
        enter_phase = (state_next != state_reg) &&
                      (state_next == ST_SCORE || state_next == ST_EXP ||
                       state_next == ST_OUT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            seq_len_reg  <= SEQ_CFG_W'(64);
            head_dim_reg <= DIM_CFG_W'(16);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_SEQ_LEN:  seq_len_reg  <= cfg_data[SEQ_CFG_W-1:0];
                    CFG_HEAD_DIM: head_dim_reg <= cfg_data[DIM_CFG_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    assign cfg_ready = 1'b1;

    always_comb
    begin
        case (state_reg)
            ST_SCORE:
            begin
                iss_first = (c_reg == '0);
                iss_last  = (c_reg == dm1);
            end
            ST_OUT:
            begin
                iss_first = (j_reg == '0);
                iss_last  = (j_reg == nm1);
            end
            default:
            begin
                iss_first = (j_reg == '0);
                iss_last  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg <= 1'b0;
            j_reg     <= '0;
            c_reg     <= '0;
        end
        else if (enter_phase)
        begin
            issue_reg <= 1'b1;
            j_reg     <= '0;
            c_reg     <= '0;
        end
        else if (issue_reg)
        begin
            case (state_reg)
                ST_SCORE:
                begin
                    if (c_reg == dm1)
                    begin
                        c_reg <= '0;
                        if (j_reg == nm1)
                            issue_reg <= 1'b0;
                        else
                            j_reg <= j_reg + 1'b1;
                    end
                    else
                    begin
                        c_reg <= c_reg + 1'b1;
                    end
                end
                ST_OUT:
                begin
                    if (j_reg == nm1)
                    begin
                        j_reg <= '0;
                        if (c_reg == dm1)
                            issue_reg <= 1'b0;
                        else
                            c_reg <= c_reg + 1'b1;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                default:
                begin
                    if (j_reg == nm1)
                        issue_reg <= 1'b0;
                    else
                        j_reg <= j_reg + 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (compute_go)
            row_reg <= row;
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            q_mem[ld_addr] <= q_value;
            k_mem[ld_addr] <= k_value;
            v_mem[ld_addr] <= v_value;
        end
        q_rd <= q_mem[q_addr];
        k_rd <= k_mem[kv_addr];
        v_rd <= v_mem[kv_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCORE && p2v_reg && p2_last)
            score_mem[p2_j] <= acc_s_next;
        s_rd <= score_mem[j_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXP && p3v_reg)
            weight_mem[p3_j] <= e4;
        w_rd <= weight_mem[j_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1v_reg <= 1'b0;
            p2v_reg <= 1'b0;
            p3v_reg <= 1'b0;
        end
        else
        begin
            p1v_reg <= issue_reg;
            p2v_reg <= p1v_reg;
            p3v_reg <= p2v_reg;
        end
    end

    assign d_w    = D_W'(mx_reg) - D_W'(s_rd);
    assign dpl    = d_w + D_W'(524288);
    assign idx    = dpl[D_W-1:20];
    assign e_full = ei3 * ef3 + WP_W'(32768);
    assign e4     = e_full[E_W+15:16];
    assign p_full = wp2 + WP_W'(32768);
    assign p_s    = {1'b0, p_full[E_W+15:16]};

    assign acc_s_next = p2_first ? SCORE_W'(prod2) : acc_s_reg + SCORE_W'(prod2);
    assign acc_o_next = p3_first ? ACC_W'(prod3) : acc_o_reg + ACC_W'(prod3);
    assign rnd        = (ACC_W+1)'(acc_o_next) + (ACC_W+1)'(32768);
    assign rsh        = rnd >>> 16;

    always_comb
    begin
        if (rsh > (ACC_W+1)'(32767))
            sat = VAL_W'(32767);
        else if (rsh < (ACC_W+1)'(-32768))
            sat = VAL_W'(-32768);
        else
            sat = VAL_W'(rsh);
    end

    always_ff @(posedge clk)
    begin
        p1_first <= iss_first;
        p1_last  <= iss_last;
        p1_j     <= j_reg;
        p1_c     <= c_reg;
        p2_first <= p1_first;
        p2_last  <= p1_last;
        p2_j     <= p1_j;
        p2_c     <= p1_c;
        p3_first <= p2_first;
        p3_last  <= p2_last;
        p3_j     <= p2_j;
        p3_c     <= p2_c;

        prod2 <= q_rd * k_rd;
        ez2   <= |idx[IDX_W-1:8];
        ei2   <= idx[7:4];
        ef2   <= idx[3:0];
        wp2   <= w_rd * inv;
        v2    <= v_rd;

        ei3   <= ez2 ? '0 : exp_int(ei2);
        ef3   <= exp_frac(ef2);
        prod3 <= p_s * v2;

        if (state_reg == ST_SCORE && p2v_reg)
        begin
            acc_s_reg <= acc_s_next;
            if (p2_last && (p2_j == '0 || acc_s_next > mx_reg))
                mx_reg <= acc_s_next;
        end
        if (state_reg == ST_EXP && p3v_reg)
            sum_reg <= (p3_j == '0) ? SUM_W'(e4) : sum_reg + SUM_W'(e4);
        if (state_reg == ST_OUT && p3v_reg)
        begin
            acc_o_reg <= acc_o_next;
            if (p3_last)
            begin
                out_value <= sat;
                out_col   <= COL_W'(p3_c);
                last      <= (p3_c == dm1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= (state_reg == ST_OUT) && p3v_reg && p3_last;
    end

    assign strobe  = strobe_reg;
    assign out_row = row_reg;

    dpa_recip #(
        .SUM_W (SUM_W)
    ) u_recip (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (recip_start),
        .divisor  (sum_reg),
        .done     (recip_done),
        .quotient (inv)
    );

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result word outside a compute run");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("result word after the final column");

    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("compute run began without a start word");

endmodule
